### design/swc_pkg.sv
`timescale 1ns / 1ps
package swc_pkg;

  // Field and arithmetic widths
  localparam int CW    = 24;          // signed coordinate width
  localparam int SW    = CW - 1;      // unsigned size width
  localparam int TF    = 16;          // time fraction bits
  localparam int NW    = CW + 2;      // signed slab numerator width
  localparam int MW    = CW + 1;      // numerator magnitude width
  localparam int QW    = MW + TF;     // dividend / quotient width, one divider stage per bit
  localparam int TW    = QW + 2;      // signed time width, room for the infinity codes
  localparam int LANES = 4;           // x low edge, x high edge, y low edge, y high edge
  localparam int IN_W  = 240;
  localparam int OUT_W = 24;
  localparam int CT_W  = 16;

  localparam logic signed [TW-1:0] T_NEG_INF = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [TW-1:0] T_POS_INF = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] T_ONE     = TW'(1) << TF;

  localparam logic signed [1:0] NRM_POS  = 2'sb01;
  localparam logic signed [1:0] NRM_NEG  = 2'sb11;
  localparam logic signed [1:0] NRM_ZERO = 2'sb00;

  // One divider lane: partial remainder, dividend bits left, quotient so far, divisor
  typedef struct packed {
    logic [CW-1:0] r;
    logic [QW-1:0] s;
    logic [QW-1:0] q;
    logic [CW-1:0] d;
  } div_t;

  // Per-item control carried beside the dividers
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             zx;
    logic             zy;
    logic             fail;
    logic             vx_neg;
    logic             vy_neg;
  } side_t;

endpackage

### design/swept_box_collision.sv
`timescale 1ns / 1ps
// Swept box collision, 2-D, fully pipelined.
// Slave channel s_axis_*: one box pair per item (moving box, displacement,
// static box), all Q15.8. Master channel m_axis_*: one result per item:
// hit flag, contact time (Q0.16), surface normal (x, y in -1..1).
// Pipeline: the input register loads on the edge that accepts an item,
// then one setup stage, 41 restoring divider stages (one quotient bit
// each, four lanes for the four slab times), sign fix, slab ordering,
// compare, and the output register.
// Throughput: one item per cycle while the output is not stalled; the
// 41-stage divider chain sets the latency, not the rate.
// Reset clears all valid bits; the pipeline is empty afterwards.
// Stall: when the output holds a result the receiver has not taken, the
// whole pipeline freezes and s_axis_tready drops in the same cycle;
// nothing is lost or repeated. Bubbles move on whenever the output is
// free.
module swept_box_collision (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // dyn_x[23:0] dyn_y[47:24] dyn_width[70:48] dyn_height[93:71]
  // vel_x[117:94] vel_y[141:118] stat_x[165:142] stat_y[189:166]
  // stat_width[212:190] stat_height[235:213], zero fill above
  input  logic [swc_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // hit[0] contact_time[16:1] normal_x[18:17] normal_y[20:19], zero fill above
  output logic [swc_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int CW = swc_pkg::CW;
  localparam int SW = swc_pkg::SW;
  localparam int NW = swc_pkg::NW;
  localparam int MW = swc_pkg::MW;
  localparam int QW = swc_pkg::QW;
  localparam int TW = swc_pkg::TW;
  localparam int TF = swc_pkg::TF;
  localparam int LN = swc_pkg::LANES;
  localparam int SH_R = (TF >= swc_pkg::CT_W) ? TF - swc_pkg::CT_W : 0;
  localparam int SH_L = (TF < swc_pkg::CT_W) ? swc_pkg::CT_W - TF : 0;

  // Global advance: everything moves when the output is free or taken
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Input register
  logic                  in_vld_q;
  logic [swc_pkg::IN_W-1:0] in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= s_axis_tdata;
    end
  end

  // Field unpack
  logic signed [CW-1:0] dyn_x, dyn_y, vel_x, vel_y, stat_x, stat_y;
  logic [SW-1:0]        dyn_width, dyn_height, stat_width, stat_height;

  assign dyn_x       = $signed(in_q[23:0]);
  assign dyn_y       = $signed(in_q[47:24]);
  assign dyn_width   = in_q[70:48];
  assign dyn_height  = in_q[93:71];
  assign vel_x       = $signed(in_q[117:94]);
  assign vel_y       = $signed(in_q[141:118]);
  assign stat_x      = $signed(in_q[165:142]);
  assign stat_y      = $signed(in_q[189:166]);
  assign stat_width  = in_q[212:190];
  assign stat_height = in_q[235:213];

  // Setup: half slab numerators (doubled edge minus doubled centre, over 2)
  logic signed [NW-1:0] num [LN];
  logic [CW-1:0]        vmag_x, vmag_y;
  swc_pkg::div_t        dv_in [LN];
  swc_pkg::side_t       sd_in;

  always_comb begin
    num[0] = NW'(stat_x) - NW'(dyn_x) - $signed(NW'(dyn_width));
    num[1] = NW'(stat_x) + $signed(NW'(stat_width)) - NW'(dyn_x);
    num[2] = NW'(stat_y) - NW'(dyn_y) - $signed(NW'(dyn_height));
    num[3] = NW'(stat_y) + $signed(NW'(stat_height)) - NW'(dyn_y);
    vmag_x = vel_x[CW-1] ? CW'(-vel_x) : CW'(vel_x);
    vmag_y = vel_y[CW-1] ? CW'(-vel_y) : CW'(vel_y);
    for (int l = 0; l < LN; l++) begin
      dv_in[l].r = '0;
      dv_in[l].q = '0;
      dv_in[l].s = {(num[l][NW-1] ? MW'(-num[l]) : MW'(num[l])), {TF{1'b0}}};
      dv_in[l].d = (l < 2) ? vmag_x : vmag_y;
      sd_in.neg[l] = num[l][NW-1] ^ ((l < 2) ? vel_x[CW-1] : vel_y[CW-1]);
    end
    sd_in.zx     = (vel_x == '0);
    sd_in.zy     = (vel_y == '0);
    sd_in.vx_neg = vel_x[CW-1];
    sd_in.vy_neg = vel_y[CW-1];
    // zero motion on an axis passes only strictly inside the grown slab
    sd_in.fail   = (sd_in.zx && sd_in.zy)
                || (sd_in.zx && !(num[0] < 0 && num[1] > 0))
                || (sd_in.zy && !(num[2] < 0 && num[3] > 0));
  end

  // Restoring divider step, one quotient bit
  function automatic swc_pkg::div_t div_step(swc_pkg::div_t x);
    logic [CW:0]   trial;
    swc_pkg::div_t y;
    trial = {x.r, x.s[QW-1]};
    y     = x;
    y.s   = {x.s[QW-2:0], 1'b0};
    if (trial >= {1'b0, x.d}) begin
      y.r = CW'(trial - {1'b0, x.d});
      y.q = {x.q[QW-2:0], 1'b1};
    end else begin
      y.r = trial[CW-1:0];
      y.q = {x.q[QW-2:0], 1'b0};
    end
    return y;
  endfunction

  // Divider pipeline: stage 0 is the setup register
  logic [QW:0]    dv_vld_q;
  swc_pkg::div_t  dv_q [QW+1][LN];
  swc_pkg::side_t sd_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (adv) begin
      dv_vld_q <= {dv_vld_q[QW-1:0], in_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= sd_in;
      for (int l = 0; l < LN; l++) begin
        dv_q[0][l] <= dv_in[l];
      end
    end
  end

  for (genvar g = 1; g <= QW; g++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sd_q[g] <= sd_q[g-1];
        for (int l = 0; l < LN; l++) begin
          dv_q[g][l] <= div_step(dv_q[g-1][l]);
        end
      end
    end
  end

  // Sign fix: floor toward minus infinity, infinities for a still axis
  logic signed [TW-1:0] t_d [LN];
  logic signed [TW-1:0] t_q [LN];
  logic [TW-1:0]        qq  [LN];
  swc_pkg::side_t       sd_p_q;
  logic                 p_vld_q;

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      qq[l] = TW'(dv_q[QW][l].q) + TW'(sd_q[QW].neg[l] && (dv_q[QW][l].r != '0));
      if (sd_q[QW].neg[l]) begin
        t_d[l] = -$signed(qq[l]);
      end else begin
        t_d[l] = $signed(qq[l]);
      end
      if ((l < 2) ? sd_q[QW].zx : sd_q[QW].zy) begin
        t_d[l] = l[0] ? swc_pkg::T_POS_INF : swc_pkg::T_NEG_INF;
      end
    end
  end

  // Slab ordering
  logic signed [TW-1:0] nx_q, fx_q, ny_q, fy_q;
  swc_pkg::side_t       sd_o_q;
  logic                 o_vld_q;

  // Compare stage
  logic signed [TW-1:0] tnear_q, tfar_q;
  logic                 miss_q, xlater_q, tie_q;
  swc_pkg::side_t       sd_c_q;
  logic                 c_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv) begin
      p_vld_q <= dv_vld_q[QW];
      o_vld_q <= p_vld_q;
      c_vld_q <= o_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < LN; l++) begin
        t_q[l] <= t_d[l];
      end
      sd_p_q <= sd_q[QW];
      nx_q   <= (t_q[0] > t_q[1]) ? t_q[1] : t_q[0];
      fx_q   <= (t_q[0] > t_q[1]) ? t_q[0] : t_q[1];
      ny_q   <= (t_q[2] > t_q[3]) ? t_q[3] : t_q[2];
      fy_q   <= (t_q[2] > t_q[3]) ? t_q[2] : t_q[3];
      sd_o_q <= sd_p_q;
      miss_q   <= (nx_q > fy_q) || (ny_q > fx_q);
      tnear_q  <= (nx_q > ny_q) ? nx_q : ny_q;
      tfar_q   <= (fx_q < fy_q) ? fx_q : fy_q;
      xlater_q <= (nx_q > ny_q);
      tie_q    <= (nx_q == ny_q);
      sd_c_q   <= sd_o_q;
    end
  end

  // Final decision and normal
  logic                         hit_d;
  logic [swc_pkg::CT_W-1:0]     ct_d;
  logic signed [1:0]            nrmx_d, nrmy_d;
  logic [swc_pkg::OUT_W-1:0]    res_d;

  always_comb begin
    hit_d  = !sd_c_q.fail && !miss_q && (tfar_q >= 0) && (tnear_q >= 0)
          && (tnear_q < swc_pkg::T_ONE);
    ct_d   = swc_pkg::CT_W'((tnear_q >>> SH_R) <<< SH_L);
    nrmx_d = swc_pkg::NRM_ZERO;
    nrmy_d = swc_pkg::NRM_ZERO;
    if (xlater_q) begin
      nrmx_d = sd_c_q.vx_neg ? swc_pkg::NRM_POS : swc_pkg::NRM_NEG;
    end else if (sd_c_q.vy_neg) begin
      nrmy_d = tie_q ? swc_pkg::NRM_ZERO : swc_pkg::NRM_POS;
    end else begin
      nrmy_d = swc_pkg::NRM_NEG;
    end
    if (hit_d) begin
      res_d = swc_pkg::OUT_W'({nrmy_d, nrmx_d, ct_d, 1'b1});
    end else begin
      res_d = '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= res_d;
    end
  end

endmodule

### bench/swept_box_collision_test.sv
`timescale 1ns / 1ps
module swept_box_collision_test;

  typedef logic signed [swc_pkg::CW-1:0] coord_t;
  typedef logic [swc_pkg::SW-1:0]        size_t;

  // One box pair as it travels on the slave channel
  typedef struct {
    coord_t dx, dy, vx, vy, sx, sy;
    size_t  dw, dh, sw, sh;
  } pair_t;

  // One collision answer
  typedef struct {
    logic                       hit;
    logic [swc_pkg::CT_W-1:0]   ct;
    logic signed [1:0]          nx, ny;
  } contact_t;

  localparam longint TSAT_L = (longint'(1) << (swc_pkg::CW + swc_pkg::TF + 2)) - 1;
  localparam longint NINF_L = -TSAT_L - 1;
  localparam longint PINF_L = TSAT_L + 1;
  localparam longint ONE_L  = longint'(1) << swc_pkg::TF;

  // Floored, saturated quotient num * 2^TF / den
  function automatic longint slab_time(longint num, longint den);
    longint unsigned a, b, s, q, r;
    a = num < 0 ? -num : num;
    b = den < 0 ? -den : den;
    s = a << swc_pkg::TF;
    q = s / b;
    r = s % b;
    if ((num < 0) != (den < 0)) begin
      if (r != 0) q = q + 1;
      if (q > TSAT_L) q = TSAT_L;
      return -longint'(q);
    end
    if (q > TSAT_L) q = TSAT_L;
    return longint'(q);
  endfunction

  // Entry/exit times on one axis; 0 when the axis can never pass
  function automatic bit axis_times(longint lo2, longint hi2, longint c2, longint v,
                                    output longint tn, output longint tf);
    longint k;
    tn = 0;
    tf = 0;
    if (v == 0) begin
      if (lo2 < c2 && c2 < hi2) begin
        tn = NINF_L;
        tf = PINF_L;
        return 1;
      end
      return 0;
    end
    tn = slab_time(lo2 - c2, 2 * v);
    tf = slab_time(hi2 - c2, 2 * v);
    if (tn > tf) begin
      k = tn;
      tn = tf;
      tf = k;
    end
    return 1;
  endfunction

  function automatic contact_t sweep_contact(pair_t p);
    contact_t c;
    longint dx, dy, dw, dh, vx, vy, sx, sy, sw, sh;
    longint nx, fx, ny, fy, tnear, tfar;
    dx = p.dx; dy = p.dy; vx = p.vx; vy = p.vy; sx = p.sx; sy = p.sy;
    dw = p.dw; dh = p.dh; sw = p.sw; sh = p.sh;
    c = '{hit: 1'b0, ct: '0, nx: swc_pkg::NRM_ZERO, ny: swc_pkg::NRM_ZERO};
    if (vx == 0 && vy == 0) return c;
    if (!axis_times(2*sx - dw, 2*sx + 2*sw + dw, 2*dx + dw, vx, nx, fx)) return c;
    if (!axis_times(2*sy - dh, 2*sy + 2*sh + dh, 2*dy + dh, vy, ny, fy)) return c;
    if (nx > fy || ny > fx) return c;
    tnear = nx > ny ? nx : ny;
    tfar  = fx < fy ? fx : fy;
    if (tfar < 0 || tnear < 0 || tnear >= ONE_L) return c;
    // later entry picks the face; equal entry times favor y
    if (nx > ny) c.nx = vx < 0 ? swc_pkg::NRM_POS : swc_pkg::NRM_NEG;
    else if (vy < 0) c.ny = (nx == ny) ? swc_pkg::NRM_ZERO : swc_pkg::NRM_POS;
    else c.ny = swc_pkg::NRM_NEG;
    c.hit = 1'b1;
    c.ct  = swc_pkg::CT_W'(tnear >>> (swc_pkg::TF - 16));
    return c;
  endfunction

  class contact_board;
    contact_t pending_res[$];
    int       errors = 0;

    function void note_pair(pair_t p);
      pending_res.push_back(sweep_contact(p));
    endfunction

    function void check_result(logic [swc_pkg::OUT_W-1:0] d);
      contact_t e;
      if (pending_res.size() == 0) begin
        $display("%0t: result %h with nothing outstanding", $time, d);
        errors++;
        return;
      end
      e = pending_res.pop_front();
      if (d[0] !== e.hit || d[16:1] !== e.ct || d[18:17] !== e.nx || d[20:19] !== e.ny) begin
        $display("%0t: mismatch exp hit=%0d t=%h n=(%0d,%0d) got hit=%0d t=%h n=(%0d,%0d)",
                 $time, e.hit, e.ct, e.nx, e.ny, d[0], d[16:1],
                 $signed(d[18:17]), $signed(d[20:19]));
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i = 0;
  logic                        rst_ni = 0;
  logic                        s_axis_tvalid = 0;
  logic                        s_axis_tready;
  logic [swc_pkg::IN_W-1:0]    s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 0;
  logic [swc_pkg::OUT_W-1:0]   m_axis_tdata;

  contact_board board = new();
  int rcv_count = 0;
  bit held = 0;

  swept_box_collision i_dut (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("swept_box_collision_test NOT OK");
    $finish;
  end

  // Receiver: random backpressure, one long hold-off
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (!held && rcv_count >= 300) begin
      held = 1;
      m_axis_tready <= 0;
      repeat (200) @(posedge clk_i);
      m_axis_tready <= 1;
    end else if (r < 3) begin
      m_axis_tready <= 0;
      repeat ($urandom_range(20, 60)) @(posedge clk_i);
      m_axis_tready <= 1;
    end else begin
      m_axis_tready <= r < 70;
    end
  end

  // Result monitor: handshake is stable between edges
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata);
      rcv_count++;
    end
  end

  int gap_len;

  task automatic send_pair(pair_t p);
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {4'b0, p.sh, p.sw, p.sy, p.sx, p.vy, p.vx, p.dh, p.dw, p.dy, p.dx};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    board.note_pair(p);
    if (gap_len > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap_len) @(posedge clk_i);
    end
  endtask

  function automatic int pick_gap(int item_no);
    int r;
    r = $urandom_range(0, 99);
    if (item_no % 400 < 100) return 0;   // stretches without gaps
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t rand_vel();
    int sh;
    coord_t v;
    sh = $urandom_range(0, swc_pkg::CW - 1);
    v = coord_t'($urandom_range(0, (1 << sh) - 1));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int k;
    p.dx = coord_t'($urandom); p.dy = coord_t'($urandom);
    p.vx = coord_t'($urandom); p.vy = coord_t'($urandom);
    p.sx = coord_t'($urandom); p.sy = coord_t'($urandom);
    p.dw = size_t'($urandom); p.dh = size_t'($urandom);
    p.sw = size_t'($urandom); p.sh = size_t'($urandom);
    if ($urandom_range(0, 99) < 15) return p;   // raw noise
    // mostly small boxes with the static box along the path
    if ($urandom_range(0, 9) != 0) begin
      p.dw = size_t'($urandom_range(0, 2048)); p.dh = size_t'($urandom_range(0, 2048));
      p.sw = size_t'($urandom_range(0, 4096)); p.sh = size_t'($urandom_range(0, 4096));
    end
    p.dx = coord_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    p.dy = coord_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    p.vx = rand_vel();
    p.vy = rand_vel();
    case ($urandom_range(0, 9))
      0: p.vx = '0;
      1: p.vy = '0;
      default: ;
    endcase
    k = $urandom_range(0, 5);
    p.sx = coord_t'(p.dx + (p.vx >>> 2) * k + $signed($urandom_range(0, 1024)) - 512);
    p.sy = coord_t'(p.dy + (p.vy >>> 2) * k + $signed($urandom_range(0, 1024)) - 512);
    return p;
  endfunction

  function automatic pair_t mk(int dx, int dy, int dw, int dh, int vx, int vy,
                               int sx, int sy, int sw, int sh);
    pair_t p;
    p.dx = coord_t'(dx); p.dy = coord_t'(dy); p.dw = size_t'(dw); p.dh = size_t'(dh);
    p.vx = coord_t'(vx); p.vy = coord_t'(vy);
    p.sx = coord_t'(sx); p.sy = coord_t'(sy); p.sw = size_t'(sw); p.sh = size_t'(sh);
    return p;
  endfunction

  initial begin
    pair_t dir_q[$];
    int MX, MN, US;
    MX = (1 << 23) - 1;
    MN = -(1 << 23);
    US = (1 << 23) - 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // no motion
    dir_q.push_back(mk(0, 0, 256, 256, 0, 0, 0, 0, 256, 256));
    // equal entry times, moving up-left: hit with zero normal
    dir_q.push_back(mk(0, 0, 0, 0, -1024, -1024, -512, -512, 256, 256));
    // equal entry times, moving down-right
    dir_q.push_back(mk(0, 0, 0, 0, 1024, 1024, 256, 256, 256, 256));
    // one axis still, centre inside / on the edge / outside
    dir_q.push_back(mk(0, 0, 256, 256, 0, 1024, 0, 512, 256, 256));
    dir_q.push_back(mk(256, 0, 256, 256, 0, 1024, 0, 512, 256, 256));
    dir_q.push_back(mk(5000, 0, 256, 256, 0, 1024, 0, 512, 256, 256));
    dir_q.push_back(mk(0, 0, 256, 256, 1024, 0, 512, 0, 256, 256));
    dir_q.push_back(mk(0, 0, 256, 256, -1024, 0, -768, 0, 256, 256));
    // already overlapping (negative entry), behind, too far
    dir_q.push_back(mk(0, 0, 512, 512, 300, 300, 100, 100, 256, 256));
    dir_q.push_back(mk(0, 0, 256, 256, -1024, 0, 512, 0, 256, 256));
    dir_q.push_back(mk(0, 0, 256, 256, 256, 0, 4096, 0, 256, 256));
    // field extremes
    dir_q.push_back(mk(MN, MN, US, US, MX, MX, MX, MX, US, US));
    dir_q.push_back(mk(MX, MX, US, US, MN, MN, MN, MN, US, US));
    dir_q.push_back(mk(MN, MX, 0, 0, 1, -1, MX, MN, 0, 0));
    dir_q.push_back(mk(MN, MN, 0, 0, MX, MX, MN + 1, MN + 1, US, US));
    dir_q.push_back(mk(-1, -1, US, 0, -1, 1, -1, -1, 0, US));
    dir_q.push_back(mk(0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
    dir_q.push_back(mk(MX, MN, US, US, MN, MX, 0, 0, US, US));
    gap_len = 0;
    foreach (dir_q[i]) send_pair(dir_q[i]);

    for (int n = 0; n < 1600; n++) begin
      gap_len = pick_gap(n);
      send_pair(rand_pair());
      // sender pause until the pipeline drains
      if (n == 900) begin
        s_axis_tvalid <= 0;
        while (board.pending_res.size() != 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 0;

    while (board.pending_res.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.errors == 0 && board.pending_res.size() == 0)
      $display("swept_box_collision_test OK");
    else
      $display("swept_box_collision_test NOT OK");
    $finish;
  end
endmodule
